FILE: src/bmm_pkg.sv
`timescale 1ns / 1ps

package bmm_pkg;

  localparam int DvdW = 22;
  localparam int SizeW = 23;
  localparam int PaW = 22;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } bmm_in_t;

  typedef struct packed {
    logic [2:0]     target;
    logic [PaW-1:0] phys_addr;
    logic           write_enable;
    logic [7:0]     write_data;
  } bmm_out_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_CART = 3'd1;
  localparam logic [2:0] TGT_BOOT = 3'd2;
  localparam logic [2:0] TGT_SRAM = 3'd3;
  localparam logic [2:0] TGT_CRAM = 3'd4;

  localparam logic [1:0] CFG_MAP_MODE  = 2'd0;
  localparam logic [1:0] CFG_CART_SIZE = 2'd1;
  localparam logic [1:0] CFG_BOOT_SIZE = 2'd2;

  localparam logic [15:0] ADDR_SRAM_BASE = 16'hC000;
  localparam logic [15:0] ADDR_CRAM_BASE = 16'h8000;
  localparam logic [15:0] ADDR_FIXED_END = 16'd1024;
  localparam logic [15:0] ADDR_CTRL_REG  = 16'hFFFC;
  localparam logic [15:0] ADDR_BANK0_REG = 16'hFFFD;

  localparam logic [SizeW-1:0] CART_SIZE_RST = 23'd262144;
  localparam logic [SizeW-1:0] BOOT_SIZE_RST = 23'd8192;

endpackage

FILE: src/banked_memory_mapper_unit.sv
`timescale 1ns / 1ps
// System RAM, cartridge RAM, fixed-kilobyte and zero-size accesses are mapped into a
// result register, then moved to the output register; banked ROM accesses first pass
// through the bit-serial remainder unit, which retires one dividend bit per cycle over
// 22 bits. No new access is taken until the last result reaches the output register.
// Reset (synchronous, active low) restores the configuration defaults, clears the
// control and bank registers and empties the output register.

module banked_memory_mapper_unit #(
  parameter int SYS_RAM_ADDR_BITS = 13,
  parameter int ROM_ADDR_BITS     = 22
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bmm_pkg::bmm_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bmm_pkg::bmm_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [bmm_pkg::SizeW-1:0] cfg_wdata
);
  import bmm_pkg::*;

  localparam logic [63:0] SysMaskW = (64'd1 << SYS_RAM_ADDR_BITS) - 64'd1;
  localparam logic [63:0] RomMaskW = (64'd1 << ROM_ADDR_BITS) - 64'd1;
  localparam logic [15:0] SysMask  = SysMaskW[15:0];
  localparam logic [PaW-1:0] RomMask = RomMaskW[PaW-1:0];

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              map_mode_r;
  logic [SizeW-1:0]  cart_size_r;
  logic [SizeW-1:0]  boot_size_r;
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        bank_r [3];
  logic [7:0]        bank_nxt [3];
  bmm_out_t          res_r, res_nxt;
  logic [2:0]        rom_tgt_r, rom_tgt_nxt;
  logic              out_valid_r, out_valid_nxt;
  bmm_out_t          out_data_r, out_data_nxt;

  logic              accept;
  logic              div_start;
  logic              div_done;
  logic [PaW-1:0]    div_rem;
  logic [DvdW-1:0]   banked;
  logic [SizeW-1:0]  rom_size;
  logic [7:0]        bank_sel;
  logic [15:0]       cram_off;
  logic              load_out;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign rom_size = map_mode_r ? cart_size_r : boot_size_r;
  assign cram_off = in_data.addr - ADDR_CRAM_BASE;

  always_comb begin
    case (in_data.addr[15:14])
      2'd0:    bank_sel = bank_r[0];
      2'd1:    bank_sel = bank_r[1];
      default: bank_sel = bank_r[2];
    endcase
  end

  assign banked = {bank_sel, in_data.addr[13:0]};

  always_comb begin
    state_nxt   = state_r;
    res_nxt     = res_r;
    rom_tgt_nxt = rom_tgt_r;
    ctrl_nxt    = ctrl_r;
    bank_nxt    = bank_r;
    div_start   = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt.target       = TGT_NONE;
          res_nxt.phys_addr    = '0;
          res_nxt.write_enable = 1'b0;
          res_nxt.write_data   = '0;
          rom_tgt_nxt          = map_mode_r ? TGT_CART : TGT_BOOT;
          state_nxt            = ST_DONE;
          if (in_data.addr >= ADDR_SRAM_BASE) begin
            res_nxt.target       = TGT_SRAM;
            res_nxt.phys_addr    = PaW'(in_data.addr & SysMask);
            res_nxt.write_enable = in_data.op;
            res_nxt.write_data   = in_data.op ? in_data.wdata : 8'd0;
          end else if (map_mode_r && ctrl_r[3] && in_data.addr >= ADDR_CRAM_BASE) begin
            res_nxt.target       = TGT_CRAM;
            res_nxt.phys_addr    = PaW'(cram_off);
            res_nxt.write_enable = in_data.op;
            res_nxt.write_data   = in_data.op ? in_data.wdata : 8'd0;
          end else if (map_mode_r && in_data.addr < ADDR_FIXED_END) begin
            res_nxt.target    = TGT_CART;
            res_nxt.phys_addr = PaW'(in_data.addr);
          end else if (rom_size != '0) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
          if (in_data.op) begin
            if (in_data.addr == ADDR_CTRL_REG) begin
              ctrl_nxt = in_data.wdata;
            end else if (in_data.addr >= ADDR_BANK0_REG) begin
              case (in_data.addr[1:0])
                2'd1:    bank_nxt[0] = in_data.wdata;
                2'd2:    bank_nxt[1] = in_data.wdata;
                default: bank_nxt[2] = in_data.wdata;
              endcase
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt.target    = rom_tgt_r;
          res_nxt.phys_addr = div_rem & RomMask;
          state_nxt         = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      map_mode_r  <= 1'b0;
      cart_size_r <= CART_SIZE_RST;
      boot_size_r <= BOOT_SIZE_RST;
      ctrl_r      <= '0;
      bank_r[0]   <= '0;
      bank_r[1]   <= '0;
      bank_r[2]   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctrl_r      <= ctrl_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAP_MODE:  map_mode_r  <= cfg_wdata[0];
          CFG_CART_SIZE: cart_size_r <= cfg_wdata;
          CFG_BOOT_SIZE: boot_size_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    res_r      <= res_nxt;
    rom_tgt_r  <= rom_tgt_nxt;
    out_data_r <= out_data_nxt;
  end

  bmm_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (banked),
    .divisor   (rom_size),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/bmm_mod_unit.sv
`timescale 1ns / 1ps

module bmm_mod_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bmm_pkg::DvdW-1:0]  dividend,
  input  logic [bmm_pkg::SizeW-1:0] divisor,
  output logic                      done,
  output logic [bmm_pkg::DvdW-1:0]  remainder
);
  import bmm_pkg::*;

  localparam int CntW = $clog2(DvdW);
  localparam logic [CntW-1:0] LastStep = CntW'(DvdW - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [DvdW-1:0]   dvd_r, dvd_nxt;
  logic [SizeW-1:0]  dsr_r, dsr_nxt;
  logic [SizeW-1:0]  rem_r, rem_nxt;
  logic [SizeW:0]    trial;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[DvdW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        trial = trial - {1'b0, dsr_r};
      end
      rem_nxt = trial[SizeW-1:0];
      dvd_nxt = {dvd_r[DvdW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LastStep) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[DvdW-1:0];

endmodule

FILE: verif/bmm_map_checker.sv
`timescale 1ns / 1ps

module bmm_map_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  bmm_pkg::bmm_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  bmm_pkg::bmm_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [bmm_pkg::SizeW-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending_maps,
  output int                        results_checked
);
  import bmm_pkg::*;

  localparam int SramBits = 13;
  localparam int MaxPrinted = 50;

  logic             map_mode_q;
  logic [SizeW-1:0] cart_size_q;
  logic [SizeW-1:0] boot_size_q;
  logic [7:0]       ctrl_q;
  logic [7:0]       bank_q [3];
  bmm_out_t         expected_maps [$];

  function automatic bmm_out_t rom_map(logic [15:0] addr, logic [SizeW-1:0] size,
                                       logic [2:0] tgt);
    bmm_out_t         r;
    logic [SizeW-1:0] banked;
    r = '0;
    if (size == '0) begin
      r.target = TGT_NONE;
      return r;
    end
    banked = {9'd0, addr[13:0]} + {1'b0, bank_q[addr[15:14]], 14'd0};
    r.target = tgt;
    r.phys_addr = PaW'(banked % size);
    return r;
  endfunction

  function automatic bmm_out_t map_access(bmm_in_t acc);
    bmm_out_t r;
    r = '0;
    if (acc.addr >= ADDR_SRAM_BASE) begin
      r.target = TGT_SRAM;
      r.phys_addr = PaW'(acc.addr[SramBits-1:0]);
      r.write_enable = (acc.op == OP_WRITE);
    end else if (map_mode_q) begin
      if (ctrl_q[3] && acc.addr >= ADDR_CRAM_BASE) begin
        r.target = TGT_CRAM;
        r.phys_addr = PaW'(acc.addr - ADDR_CRAM_BASE);
        r.write_enable = (acc.op == OP_WRITE);
      end else if (acc.addr < ADDR_FIXED_END) begin
        r.target = TGT_CART;
        r.phys_addr = PaW'(acc.addr);
      end else begin
        r = rom_map(acc.addr, cart_size_q, TGT_CART);
      end
    end else begin
      r = rom_map(acc.addr, boot_size_q, TGT_BOOT);
    end
    r.write_data = r.write_enable ? acc.wdata : 8'd0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < MaxPrinted) begin
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    bmm_out_t want;
    if (!rst_n) begin
      map_mode_q = 1'b0;
      cart_size_q = CART_SIZE_RST;
      boot_size_q = BOOT_SIZE_RST;
      ctrl_q = 8'd0;
      for (int i = 0; i < 3; i++) begin
        bank_q[i] = 8'd0;
      end
      expected_maps.delete();
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAP_MODE:  map_mode_q = cfg_wdata[0];
          CFG_CART_SIZE: cart_size_q = cfg_wdata;
          CFG_BOOT_SIZE: boot_size_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_maps.push_back(map_access(in_data));
        if (in_data.op == OP_WRITE) begin
          if (in_data.addr == ADDR_CTRL_REG) begin
            ctrl_q = in_data.wdata;
          end else if (in_data.addr >= ADDR_BANK0_REG) begin
            bank_q[2'(in_data.addr - ADDR_BANK0_REG)] = in_data.wdata;
          end
        end
      end
      if (out_valid && out_ready) begin
        if (expected_maps.size() == 0) begin
          report_mismatch("result with no access pending", 32'(out_data.phys_addr), 32'd0);
        end else begin
          want = expected_maps.pop_front();
          results_checked++;
          if (out_data.target !== want.target) begin
            report_mismatch("target", 32'(out_data.target), 32'(want.target));
          end
          if (out_data.phys_addr !== want.phys_addr) begin
            report_mismatch("phys_addr", 32'(out_data.phys_addr), 32'(want.phys_addr));
          end
          if (out_data.write_enable !== want.write_enable) begin
            report_mismatch("write_enable", 32'(out_data.write_enable),
                            32'(want.write_enable));
          end
          if (out_data.write_data !== want.write_data) begin
            report_mismatch("write_data", 32'(out_data.write_data), 32'(want.write_data));
          end
        end
      end
    end
    pending_maps = expected_maps.size();
  end

endmodule

FILE: verif/banked_memory_mapper_unit_test.sv
`timescale 1ns / 1ps

module banked_memory_mapper_unit_test;

  import bmm_pkg::*;

  localparam int HoldCycles = 300;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 80;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  bmm_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  bmm_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_MAP_MODE;
  logic [SizeW-1:0] cfg_wdata = '0;

  int fail_count;
  int pending_maps;
  int results_checked;
  int accesses_sent = 0;
  int layouts_used = 1;
  bit hold_off_req = 1'b0;

  always #10 clk = ~clk;

  banked_memory_mapper_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  bmm_map_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending_maps   (pending_maps),
    .results_checked(results_checked)
  );

  function automatic bmm_in_t access(logic op, logic [15:0] addr, logic [7:0] wdata);
    bmm_in_t a;
    a.op = op;
    a.addr = addr;
    a.wdata = wdata;
    return a;
  endfunction

  // Mostly control and bank-register loads, system RAM and ROM-window
  // traffic, with some fully random addresses mixed in.
  function automatic bmm_in_t random_access();
    bmm_in_t a;
    int      pick;
    a.op = 1'($urandom_range(1));
    a.addr = 16'($urandom());
    a.wdata = 8'($urandom());
    pick = $urandom_range(99);
    if (pick < 12) begin
      a.op = OP_WRITE;
      a.addr = ADDR_CTRL_REG + 16'($urandom_range(3));
      if (a.addr != ADDR_CTRL_REG && $urandom_range(1) == 0) begin
        a.wdata = 8'($urandom_range(15));
      end
    end else if (pick < 35) begin
      a.addr = ADDR_SRAM_BASE | 16'($urandom_range(16'h3FFF));
    end else if (pick < 50) begin
      a.addr = 16'($urandom_range(16'h0FFF));
    end else if (pick < 90) begin
      a.addr = 16'($urandom_range(16'hBFFF));
    end
    return a;
  endfunction

  task automatic put_access(bmm_in_t a);
    in_valid <= 1'b1;
    in_data <= a;
    do @(posedge clk); while (!in_ready);
    accesses_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_maps != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= SizeW'(value);
    @(posedge clk);
  endtask

  task automatic set_layout(logic mode, int unsigned cart_size, int unsigned boot_size);
    write_reg(CFG_MAP_MODE, mode);
    write_reg(CFG_CART_SIZE, cart_size);
    write_reg(CFG_BOOT_SIZE, boot_size);
    cfg_we <= 1'b0;
    layouts_used++;
  endtask

  task automatic drive_accesses(int n, bit dense);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = dense ? left : $urandom_range(1, 12);
      if (burst > left) begin
        burst = left;
      end
      repeat (burst) put_access(random_access());
      left -= burst;
      gap = dense ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : rx_pattern
    int mode;
    int mode_left;
    int tick;
    bit hold_off_done;
    mode = 0;
    mode_left = 0;
    tick = 0;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(1));
          2: out_ready <= (tick % 4 == 0);
          default: out_ready <= ($urandom_range(9) != 0);
        endcase
      end
    end
  end

  initial begin
    #6000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic        modes [NumPhases];
    int unsigned cart_sizes [NumPhases];
    int unsigned boot_sizes [NumPhases];
    modes = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    cart_sizes = '{4194304, 1, 16385, 1024, 65536, 0, 8388607, 0};
    boot_sizes = '{4194304, 1, 3, 0, 16384, 1000, 1, 0};
    cart_sizes[NumPhases-1] = $urandom_range(1, 4194304);
    boot_sizes[NumPhases-1] = $urandom_range(1, 4194304);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Boot layout with reset sizes, then bank and control loads.
    put_access(access(OP_READ, 16'h0000, 8'h00));
    put_access(access(OP_READ, 16'hBFFF, 8'hFF));
    put_access(access(OP_READ, 16'h4000, 8'h00));
    put_access(access(OP_READ, 16'hC000, 8'h00));
    put_access(access(OP_WRITE, 16'hE123, 8'hA5));
    put_access(access(OP_WRITE, ADDR_BANK0_REG, 8'hFF));
    put_access(access(OP_READ, 16'h3FFF, 8'h00));
    put_access(access(OP_WRITE, 16'hFFFE, 8'h80));
    put_access(access(OP_READ, 16'h7ABC, 8'h00));
    put_access(access(OP_WRITE, 16'hFFFF, 8'h01));
    put_access(access(OP_WRITE, 16'h8000, 8'h55));
    put_access(access(OP_WRITE, ADDR_CTRL_REG, 8'h08));
    put_access(access(OP_READ, ADDR_CTRL_REG, 8'h00));
    settle();

    // Cartridge layout: fixed first kilobyte and cartridge RAM window.
    write_reg(CFG_MAP_MODE, 1);
    cfg_we <= 1'b0;
    layouts_used++;
    put_access(access(OP_READ, 16'h0000, 8'h00));
    put_access(access(OP_READ, 16'h03FF, 8'h00));
    put_access(access(OP_READ, ADDR_FIXED_END, 8'h00));
    put_access(access(OP_READ, ADDR_CRAM_BASE, 8'h00));
    put_access(access(OP_WRITE, 16'hBFFF, 8'hFF));
    put_access(access(OP_WRITE, ADDR_CTRL_REG, 8'h00));
    put_access(access(OP_READ, 16'hBFFF, 8'h00));
    put_access(access(OP_WRITE, 16'h5000, 8'h12));
    put_access(access(OP_WRITE, ADDR_BANK0_REG, 8'h00));
    settle();

    // A cartridge size of zero leaves only the fixed kilobyte of cartridge ROM mapped.
    write_reg(CFG_CART_SIZE, 0);
    cfg_we <= 1'b0;
    layouts_used++;
    put_access(access(OP_READ, ADDR_FIXED_END, 8'h00));
    put_access(access(OP_READ, 16'h03FF, 8'h00));
    put_access(access(OP_READ, ADDR_CRAM_BASE, 8'h00));
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      set_layout(modes[p], cart_sizes[p], boot_sizes[p]);
      if (p == 1) begin
        hold_off_req = 1'b1;
      end
      drive_accesses(PhaseItems, p == 1);
      settle();
    end

    $display("Checked %0d results from %0d accesses over %0d mapper layouts.",
             results_checked, accesses_sent, layouts_used);
    $display("Included a %0d-cycle output stall with the input held busy.", HoldCycles);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/bmm_pkg.sv
src/bmm_mod_unit.sv
src/banked_memory_mapper_unit.sv
verif/bmm_map_checker.sv
verif/banked_memory_mapper_unit_test.sv
